### rtl/stt_pkg.sv
// stt_pkg: shared widths, token record type, token kind codes and small helpers
// for the source text tokenizer; used by stt_scan, stt_tok_buffer and the top level.
// No dependencies.
package stt_pkg;

  localparam int OFFSET_BITS = 20;
  localparam int LINE_BITS   = 16;
  localparam int COLUMN_BITS = 12;
  localparam int LEN_BITS    = 12;
  localparam int KIND_BITS   = 5;
  localparam int MAX_TOKENS  = 3;
  localparam int CNT_BITS    = 2;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [LINE_BITS-1:0]   line_t;
  typedef logic [COLUMN_BITS-1:0] col_t;
  typedef logic [LEN_BITS-1:0]    len_t;
  typedef logic [KIND_BITS-1:0]   kind_t;
  typedef logic [CNT_BITS-1:0]    count_t;

  typedef struct packed {
    kind_t   kind;
    offset_t start;
    len_t    len;
    line_t   line;
    col_t    col;
  } token_t;

  localparam len_t LEN_MAX = {LEN_BITS{1'b1}};

  // token kinds
  localparam kind_t K_LPAREN   = 5'd0;
  localparam kind_t K_RPAREN   = 5'd1;
  localparam kind_t K_LBRACKET = 5'd2;
  localparam kind_t K_RBRACKET = 5'd3;
  localparam kind_t K_LBRACE   = 5'd4;
  localparam kind_t K_RBRACE   = 5'd5;
  localparam kind_t K_ASSIGN   = 5'd6;
  localparam kind_t K_EQ       = 5'd7;
  localparam kind_t K_NOT      = 5'd8;
  localparam kind_t K_NE       = 5'd9;
  localparam kind_t K_GT       = 5'd10;
  localparam kind_t K_GE       = 5'd11;
  localparam kind_t K_LT       = 5'd12;
  localparam kind_t K_LE       = 5'd13;
  localparam kind_t K_PLUS     = 5'd14;
  localparam kind_t K_INC      = 5'd15;
  localparam kind_t K_MINUS    = 5'd16;
  localparam kind_t K_DEC      = 5'd17;
  localparam kind_t K_SEMI     = 5'd18;
  localparam kind_t K_SLASH    = 5'd19;
  localparam kind_t K_STAR     = 5'd20;
  localparam kind_t K_STRING   = 5'd21;
  localparam kind_t K_NUMBER   = 5'd22;
  localparam kind_t K_IDENT    = 5'd23;
  localparam kind_t K_EOF      = 5'd24;
  localparam kind_t K_BAD      = 5'd25;
  localparam kind_t K_UNTERM   = 5'd26;

  // saturate an offset difference to the length field
  function automatic len_t sat_len(input offset_t diff);
    localparam int CMP_BITS = (OFFSET_BITS > LEN_BITS) ? OFFSET_BITS : LEN_BITS;
    logic [CMP_BITS-1:0] wide;
    wide = CMP_BITS'(diff);
    if (wide > CMP_BITS'(LEN_MAX)) begin
      return LEN_MAX;
    end
    return len_t'(wide);
  endfunction

  function automatic token_t make_tok(input kind_t tk_kind, input offset_t tk_start,
                                      input len_t tk_len, input line_t tk_line,
                                      input col_t tk_col);
    token_t t;
    t.kind  = tk_kind;
    t.start = tk_start;
    t.len   = tk_len;
    t.line  = tk_line;
    t.col   = tk_col;
    return t;
  endfunction

endpackage

### rtl/stt_scan.sv
// stt_scan: scanner state registers and the combinational next-state and token
// logic for one source byte; produces up to three tokens per byte.
// Depends on stt_pkg.
module stt_scan (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       step,
  input  logic [7:0]                                 char_byte,
  input  logic                                       end_of_source,
  output stt_pkg::token_t [stt_pkg::MAX_TOKENS-1:0]  toks,
  output stt_pkg::count_t                            tok_count
);

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_ASSIGN  = 4'd1,
    M_NOT     = 4'd2,
    M_GT      = 4'd3,
    M_LT      = 4'd4,
    M_PLUS    = 4'd5,
    M_MINUS   = 4'd6,
    M_SLASH   = 4'd7,
    M_COMMENT = 4'd8,
    M_INT     = 4'd9,
    M_DOT     = 4'd10,
    M_FRAC    = 4'd11,
    M_IDENT   = 4'd12,
    M_STRING  = 4'd13,
    M_ERROR   = 4'd14
  } mode_t;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0a;
  localparam logic [7:0] CH_CR       = 8'h0d;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_BANG     = 8'h21;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_STAR     = 8'h2a;
  localparam logic [7:0] CH_PLUS     = 8'h2b;
  localparam logic [7:0] CH_MINUS    = 8'h2d;
  localparam logic [7:0] CH_DOT      = 8'h2e;
  localparam logic [7:0] CH_SLASH    = 8'h2f;
  localparam logic [7:0] CH_SEMI     = 8'h3b;
  localparam logic [7:0] CH_LT       = 8'h3c;
  localparam logic [7:0] CH_EQUAL    = 8'h3d;
  localparam logic [7:0] CH_GT       = 8'h3e;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_RBRACKET = 8'h5d;
  localparam logic [7:0] CH_UNDER    = 8'h5f;
  localparam logic [7:0] CH_LBRACE   = 8'h7b;
  localparam logic [7:0] CH_RBRACE   = 8'h7d;

  localparam stt_pkg::len_t LEN_ZERO = stt_pkg::len_t'(0);
  localparam stt_pkg::len_t LEN_ONE  = stt_pkg::len_t'(1);
  localparam stt_pkg::len_t LEN_TWO  = stt_pkg::len_t'(2);
  localparam stt_pkg::col_t COL_ONE  = stt_pkg::col_t'(1);
  localparam stt_pkg::line_t LINE_ONE = stt_pkg::line_t'(1);

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic [7:0] op_second(input mode_t m);
    case (m)
      M_PLUS:  return CH_PLUS;
      M_MINUS: return CH_MINUS;
      default: return CH_EQUAL;
    endcase
  endfunction

  function automatic stt_pkg::kind_t op_short(input mode_t m);
    case (m)
      M_ASSIGN: return stt_pkg::K_ASSIGN;
      M_NOT:    return stt_pkg::K_NOT;
      M_GT:     return stt_pkg::K_GT;
      M_LT:     return stt_pkg::K_LT;
      M_PLUS:   return stt_pkg::K_PLUS;
      default:  return stt_pkg::K_MINUS;
    endcase
  endfunction

  function automatic stt_pkg::kind_t op_long(input mode_t m);
    case (m)
      M_ASSIGN: return stt_pkg::K_EQ;
      M_NOT:    return stt_pkg::K_NE;
      M_GT:     return stt_pkg::K_GE;
      M_LT:     return stt_pkg::K_LE;
      M_PLUS:   return stt_pkg::K_INC;
      default:  return stt_pkg::K_DEC;
    endcase
  endfunction

  function automatic stt_pkg::offset_t dec_off(input stt_pkg::offset_t o);
    return (o != '0) ? o - stt_pkg::offset_t'(1) : o;
  endfunction

  function automatic stt_pkg::col_t dec_col(input stt_pkg::col_t c);
    return (c > COL_ONE) ? c - COL_ONE : COL_ONE;
  endfunction

  // length with the trailing dot dropped
  function automatic stt_pkg::len_t len_less_one(input stt_pkg::offset_t diff);
    return stt_pkg::sat_len((diff != '0) ? diff - stt_pkg::offset_t'(1) : diff);
  endfunction

  mode_t             mode_r, mode_p1;
  stt_pkg::offset_t  off_r, tso_r, off_p1, tso_p1, off_adv;
  stt_pkg::col_t     tsc_r, col_r, tsc_p1, col_p1, col_adv;
  stt_pkg::line_t    line_r, line_p1, line_adv;

  stt_pkg::token_t   p1_tok0, p1_tok1, d_tok;
  stt_pkg::count_t   p1_count;
  logic              disp, d_valid, hit_nul;

  stt_pkg::token_t   p2_tok0, p2_tok1, p2_tok2, eof_tok;
  stt_pkg::count_t   p2_count;
  stt_pkg::len_t     len_p1;
  logic [stt_pkg::CNT_BITS:0] sum_count;

  // position after the current byte, saturating
  assign off_adv  = (off_r != '1) ? off_r + stt_pkg::offset_t'(1) : off_r;
  assign line_adv = ((char_byte == CH_NL) && (line_r != '1)) ?
                    line_r + stt_pkg::line_t'(1) : line_r;
  assign col_adv  = (char_byte == CH_NL) ? COL_ONE :
                    ((col_r != '1) ? col_r + stt_pkg::col_t'(1) : col_r);

  // mode step, then dispatch of the byte when the pending token ends
  always_comb begin
    mode_p1  = mode_r;
    off_p1   = off_r;
    tso_p1   = tso_r;
    tsc_p1   = tsc_r;
    line_p1  = line_r;
    col_p1   = col_r;
    p1_tok0  = '0;
    p1_tok1  = '0;
    p1_count = '0;
    disp     = 1'b0;
    d_tok    = '0;
    d_valid  = 1'b0;
    hit_nul  = 1'b0;

    case (mode_r)
      M_ASSIGN, M_NOT, M_GT, M_LT, M_PLUS, M_MINUS: begin
        if (char_byte == op_second(mode_r)) begin
          p1_tok0  = stt_pkg::make_tok(op_long(mode_r), tso_r, LEN_TWO, line_r, tsc_r);
          p1_count = stt_pkg::count_t'(1);
          off_p1   = off_adv;
          line_p1  = line_adv;
          col_p1   = col_adv;
          mode_p1  = M_IDLE;
        end else begin
          p1_tok0  = stt_pkg::make_tok(op_short(mode_r), tso_r, LEN_ONE, line_r, tsc_r);
          p1_count = stt_pkg::count_t'(1);
          disp     = 1'b1;
        end
      end
      M_ERROR: begin
      end
      M_SLASH: begin
        if (char_byte == CH_SLASH) begin
          mode_p1 = M_COMMENT;
          off_p1  = off_adv;
          line_p1 = line_adv;
          col_p1  = col_adv;
        end else begin
          p1_tok0  = stt_pkg::make_tok(stt_pkg::K_SLASH, tso_r, LEN_ONE, line_r, tsc_r);
          p1_count = stt_pkg::count_t'(1);
          disp     = 1'b1;
        end
      end
      M_COMMENT: begin
        if (char_byte == CH_NL) begin
          disp = 1'b1;
        end else begin
          off_p1  = off_adv;
          line_p1 = line_adv;
          col_p1  = col_adv;
        end
      end
      M_INT: begin
        if (is_digit(char_byte) || (char_byte == CH_DOT)) begin
          off_p1  = off_adv;
          line_p1 = line_adv;
          col_p1  = col_adv;
          if (char_byte == CH_DOT) begin
            mode_p1 = M_DOT;
          end
        end else begin
          p1_tok0  = stt_pkg::make_tok(stt_pkg::K_NUMBER, tso_r,
                                       stt_pkg::sat_len(off_r - tso_r), line_r, tsc_r);
          p1_count = stt_pkg::count_t'(1);
          disp     = 1'b1;
        end
      end
      M_DOT: begin
        if (is_digit(char_byte)) begin
          off_p1  = off_adv;
          line_p1 = line_adv;
          col_p1  = col_adv;
          mode_p1 = M_FRAC;
        end else begin
          // number without the dot, bad char at the dot, byte dropped
          p1_tok0  = stt_pkg::make_tok(stt_pkg::K_NUMBER, tso_r,
                                       len_less_one(off_r - tso_r), line_r, tsc_r);
          p1_tok1  = stt_pkg::make_tok(stt_pkg::K_BAD, dec_off(off_r), LEN_ONE, line_r,
                                       dec_col(col_r));
          p1_count = stt_pkg::count_t'(2);
          mode_p1  = M_ERROR;
        end
      end
      M_FRAC, M_IDENT: begin
        if (is_digit(char_byte) || ((mode_r == M_IDENT) && is_alpha(char_byte))) begin
          off_p1  = off_adv;
          line_p1 = line_adv;
          col_p1  = col_adv;
        end else begin
          p1_tok0  = stt_pkg::make_tok((mode_r == M_FRAC) ? stt_pkg::K_NUMBER :
                                       stt_pkg::K_IDENT, tso_r,
                                       stt_pkg::sat_len(off_r - tso_r), line_r, tsc_r);
          p1_count = stt_pkg::count_t'(1);
          disp     = 1'b1;
        end
      end
      M_STRING: begin
        if (char_byte == CH_QUOTE) begin
          off_p1   = off_adv;
          line_p1  = line_adv;
          col_p1   = col_adv;
          p1_tok0  = stt_pkg::make_tok(stt_pkg::K_STRING, tso_r,
                                       stt_pkg::sat_len(off_adv - tso_r), line_adv, tsc_r);
          p1_count = stt_pkg::count_t'(1);
          mode_p1  = M_IDLE;
        end else if (char_byte == CH_NL) begin
          p1_tok0  = stt_pkg::make_tok(stt_pkg::K_UNTERM, tso_r,
                                       stt_pkg::sat_len(off_r - tso_r), line_r, tsc_r);
          p1_count = stt_pkg::count_t'(1);
          mode_p1  = M_ERROR;
        end else begin
          off_p1  = off_adv;
          line_p1 = line_adv;
          col_p1  = col_adv;
        end
      end
      default: begin
        disp = 1'b1;
      end
    endcase

    if (disp) begin
      mode_p1 = M_IDLE;
      case (char_byte)
        CH_LPAREN, CH_RPAREN, CH_LBRACKET, CH_RBRACKET, CH_LBRACE, CH_RBRACE,
        CH_SEMI, CH_STAR: begin
          d_valid = 1'b1;
          case (char_byte)
            CH_LPAREN:   d_tok.kind = stt_pkg::K_LPAREN;
            CH_RPAREN:   d_tok.kind = stt_pkg::K_RPAREN;
            CH_LBRACKET: d_tok.kind = stt_pkg::K_LBRACKET;
            CH_RBRACKET: d_tok.kind = stt_pkg::K_RBRACKET;
            CH_LBRACE:   d_tok.kind = stt_pkg::K_LBRACE;
            CH_RBRACE:   d_tok.kind = stt_pkg::K_RBRACE;
            CH_SEMI:     d_tok.kind = stt_pkg::K_SEMI;
            default:     d_tok.kind = stt_pkg::K_STAR;
          endcase
          d_tok.start = off_r;
          d_tok.len   = LEN_ONE;
          d_tok.line  = line_r;
          d_tok.col   = col_r;
          off_p1  = off_adv;
          line_p1 = line_adv;
          col_p1  = col_adv;
        end
        CH_SPACE, CH_TAB, CH_CR, CH_NL: begin
          off_p1  = off_adv;
          line_p1 = line_adv;
          col_p1  = col_adv;
        end
        CH_NUL: begin
          d_valid = 1'b1;
          d_tok   = stt_pkg::make_tok(stt_pkg::K_EOF, off_r, LEN_ZERO, line_r, col_r);
          hit_nul = 1'b1;
        end
        default: begin
          if ((char_byte == CH_EQUAL) || (char_byte == CH_BANG) || (char_byte == CH_GT) ||
              (char_byte == CH_LT) || (char_byte == CH_PLUS) || (char_byte == CH_MINUS) ||
              (char_byte == CH_SLASH) || (char_byte == CH_QUOTE) ||
              is_digit(char_byte) || is_alpha(char_byte)) begin
            // token start
            tso_p1  = off_r;
            tsc_p1  = col_r;
            off_p1  = off_adv;
            line_p1 = line_adv;
            col_p1  = col_adv;
            case (char_byte)
              CH_EQUAL: mode_p1 = M_ASSIGN;
              CH_BANG:  mode_p1 = M_NOT;
              CH_GT:    mode_p1 = M_GT;
              CH_LT:    mode_p1 = M_LT;
              CH_PLUS:  mode_p1 = M_PLUS;
              CH_MINUS: mode_p1 = M_MINUS;
              CH_SLASH: mode_p1 = M_SLASH;
              CH_QUOTE: mode_p1 = M_STRING;
              default:  mode_p1 = is_digit(char_byte) ? M_INT : M_IDENT;
            endcase
          end else begin
            d_valid = 1'b1;
            d_tok   = stt_pkg::make_tok(stt_pkg::K_BAD, off_r, LEN_ONE, line_r, col_r);
            mode_p1 = M_ERROR;
          end
        end
      endcase

      if (d_valid) begin
        if (p1_count == '0) begin
          p1_tok0 = d_tok;
        end else begin
          p1_tok1 = d_tok;
        end
        p1_count = p1_count + stt_pkg::count_t'(1);
      end
    end
  end

  assign len_p1  = stt_pkg::sat_len(off_p1 - tso_p1);
  assign eof_tok = stt_pkg::make_tok(stt_pkg::K_EOF, off_p1, LEN_ZERO, line_p1, col_p1);

  // end of source: finish the pending token, then the eof token
  always_comb begin
    p2_tok0  = '0;
    p2_tok1  = '0;
    p2_tok2  = '0;
    p2_count = '0;
    if (end_of_source && !hit_nul) begin
      case (mode_p1)
        M_ASSIGN, M_NOT, M_GT, M_LT, M_PLUS, M_MINUS: begin
          p2_tok0  = stt_pkg::make_tok(op_short(mode_p1), tso_p1, LEN_ONE, line_p1, tsc_p1);
          p2_count = stt_pkg::count_t'(1);
        end
        M_SLASH: begin
          p2_tok0  = stt_pkg::make_tok(stt_pkg::K_SLASH, tso_p1, LEN_ONE, line_p1, tsc_p1);
          p2_count = stt_pkg::count_t'(1);
        end
        M_INT, M_FRAC: begin
          p2_tok0  = stt_pkg::make_tok(stt_pkg::K_NUMBER, tso_p1, len_p1, line_p1, tsc_p1);
          p2_count = stt_pkg::count_t'(1);
        end
        M_DOT: begin
          p2_tok0  = stt_pkg::make_tok(stt_pkg::K_NUMBER, tso_p1,
                                       len_less_one(off_p1 - tso_p1), line_p1, tsc_p1);
          p2_tok1  = stt_pkg::make_tok(stt_pkg::K_BAD, dec_off(off_p1), LEN_ONE, line_p1,
                                       dec_col(col_p1));
          p2_count = stt_pkg::count_t'(2);
        end
        M_IDENT: begin
          p2_tok0  = stt_pkg::make_tok(stt_pkg::K_IDENT, tso_p1, len_p1, line_p1, tsc_p1);
          p2_count = stt_pkg::count_t'(1);
        end
        M_STRING: begin
          p2_tok0  = stt_pkg::make_tok(stt_pkg::K_UNTERM, tso_p1, len_p1, line_p1, tsc_p1);
          p2_count = stt_pkg::count_t'(1);
        end
        default: begin
        end
      endcase
      case (p2_count)
        stt_pkg::count_t'(0): p2_tok0 = eof_tok;
        stt_pkg::count_t'(1): p2_tok1 = eof_tok;
        default:              p2_tok2 = eof_tok;
      endcase
      p2_count = p2_count + stt_pkg::count_t'(1);
    end
  end

  // merge both groups, keeping the first three
  always_comb begin
    case (p1_count)
      stt_pkg::count_t'(0): toks = {p2_tok2, p2_tok1, p2_tok0};
      stt_pkg::count_t'(1): toks = {p2_tok1, p2_tok0, p1_tok0};
      default:              toks = {p2_tok0, p1_tok1, p1_tok0};
    endcase
  end

  assign sum_count = {1'b0, p1_count} + {1'b0, p2_count};
  assign tok_count = (sum_count > (stt_pkg::CNT_BITS+1)'(stt_pkg::MAX_TOKENS)) ?
                     stt_pkg::count_t'(stt_pkg::MAX_TOKENS) :
                     sum_count[stt_pkg::CNT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n || (step && (hit_nul || end_of_source))) begin
      mode_r <= M_IDLE;
      off_r  <= '0;
      tso_r  <= '0;
      tsc_r  <= COL_ONE;
      line_r <= LINE_ONE;
      col_r  <= COL_ONE;
    end else if (step) begin
      mode_r <= mode_p1;
      off_r  <= off_p1;
      tso_r  <= tso_p1;
      tsc_r  <= tsc_p1;
      line_r <= line_p1;
      col_r  <= col_p1;
    end
  end

endmodule

### rtl/stt_tok_buffer.sv
// stt_tok_buffer: result register for the tokens of one byte, drained one
// token per output transaction. Depends on stt_pkg.
module stt_tok_buffer (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      load,
  input  stt_pkg::count_t                           load_count,
  input  stt_pkg::token_t [stt_pkg::MAX_TOKENS-1:0] load_toks,
  input  logic                                      out_ready,
  output logic                                      out_valid,
  output stt_pkg::token_t                           head,
  output logic                                      head_last,
  output logic                                      can_take
);

  stt_pkg::token_t [stt_pkg::MAX_TOKENS-1:0] tok_r, tok_nxt;
  stt_pkg::count_t                           cnt_r, cnt_nxt;
  logic                                      pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign head      = tok_r[0];
  assign head_last = (cnt_r == stt_pkg::count_t'(1));
  // room for a new run once the last token of this one leaves
  assign can_take  = (cnt_r == '0) || (head_last && out_ready);

  always_comb begin
    tok_nxt = tok_r;
    cnt_nxt = cnt_r;
    if (load) begin
      tok_nxt = load_toks;
      cnt_nxt = load_count;
    end else if (pop) begin
      for (int i = 0; i < stt_pkg::MAX_TOKENS - 1; i++) begin
        tok_nxt[i] = tok_r[i+1];
      end
      cnt_nxt = cnt_r - stt_pkg::count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/source_text_tokenizer.sv
// source_text_tokenizer: top level of the streaming tokenizer; byte channel in,
// token channel out. Depends on stt_pkg, stt_scan and stt_tok_buffer.
//
// The block takes one source byte per input transaction and returns tokens
// (kind, start offset, length, line, start column) as soon as their end is
// known. A byte is accepted in every cycle as long as each byte gives at most
// one token and the output side keeps up; a byte that gives more tokens (at most
// three) holds the input while its earlier tokens are handed out, because the token buffer
// behind the scanner hands out one token per output transaction and takes a
// new run only as its last token leaves. Bytes that give no token (blanks,
// comments, the middle of a lexeme) never hold the input. There is no clearing
// pass after reset: the first byte may follow reset at once.
// out_last_of_run marks the final token of the run caused by one byte. A NUL
// byte or in_end_of_source ends the source with an eof token and the scanner
// starts over at offset 0, line 1, column 1. After a bad character or an
// unterminated string, bytes are swallowed until the end of the source.
module source_text_tokenizer (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_char_byte,
  input  logic                    in_end_of_source,
  output logic                    out_valid,
  input  logic                    out_ready,
  output stt_pkg::kind_t          out_token_kind,
  output stt_pkg::offset_t        out_start_offset,
  output stt_pkg::len_t           out_token_length,
  output stt_pkg::line_t          out_line_number,
  output stt_pkg::col_t           out_start_column,
  output logic                    out_last_of_run
);

  logic                                      step;
  stt_pkg::token_t [stt_pkg::MAX_TOKENS-1:0] run_toks;
  stt_pkg::count_t                           run_count;
  stt_pkg::token_t                           head;

  // input transaction moves the scanner and loads its tokens together
  assign step = in_valid && in_ready;

  // mode register and counters, with the per-byte token logic
  stt_scan u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .char_byte     (in_char_byte),
    .end_of_source (in_end_of_source),
    .toks          (run_toks),
    .tok_count     (run_count)
  );

  // result register, drained one token at a time
  stt_tok_buffer u_buffer (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .load_count (run_count),
    .load_toks  (run_toks),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .head       (head),
    .head_last  (out_last_of_run),
    .can_take   (in_ready)
  );

  // head token onto the output fields
  assign out_token_kind   = head.kind;
  assign out_start_offset = head.start;
  assign out_token_length = head.len;
  assign out_line_number  = head.line;
  assign out_start_column = head.col;

endmodule

### test/source_text_tokenizer_tb.sv
// source_text_tokenizer_tb: self-checking testbench for the streaming source tokenizer.
// Feeds byte transactions, predicts the token stream with an in-bench scanner model and
// compares every token transaction field by field. Depends on stt_pkg and source_text_tokenizer.
module source_text_tokenizer_tb;
  import stt_pkg::*;

  // run limits and pacing
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RESET_CYCLES  = 11;
  localparam int IDLE_PERCENT  = 20;
  localparam int CALM_CYCLES   = 150;
  localparam int LONG_HOLD     = 64;
  localparam int RANDOM_BYTES  = 250;
  localparam int DRAIN_CYCLES  = 16;
  localparam int PRINT_LIMIT   = 40;

  // control characters the scanner cares about
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam offset_t OFFSET_TOP = '1;
  localparam line_t   LINE_TOP   = '1;
  localparam col_t    COLUMN_TOP = '1;

  // scanner modes of the predictor; the pending-operator modes keep the order
  // = ! > < + - so that the token kind follows from the mode
  typedef enum logic [3:0] {
    SCAN_IDLE       = 4'd0,
    SCAN_EQ_PEND    = 4'd1,
    SCAN_BANG_PEND  = 4'd2,
    SCAN_GT_PEND    = 4'd3,
    SCAN_LT_PEND    = 4'd4,
    SCAN_PLUS_PEND  = 4'd5,
    SCAN_MINUS_PEND = 4'd6,
    SCAN_SLASH      = 4'd7,
    SCAN_COMMENT    = 4'd8,
    SCAN_INT        = 4'd9,
    SCAN_DOT        = 4'd10,
    SCAN_FRAC       = 4'd11,
    SCAN_IDENT      = 4'd12,
    SCAN_STRING     = 4'd13,
    SCAN_ERROR      = 4'd14
  } scan_mode_e;

  typedef struct {
    token_t tok;
    logic   last;
  } expected_token_t;

  typedef struct packed {
    logic [7:0] c;
    logic       eos;
  } src_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_byte = 8'h00;
  logic       in_end_of_source = 1'b0;

  logic    out_valid;
  logic    out_ready = 1'b0;
  kind_t   out_token_kind;
  offset_t out_start_offset;
  len_t    out_token_length;
  line_t   out_line_number;
  col_t    out_start_column;
  logic    out_last_of_run;

  source_text_tokenizer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_byte     (in_char_byte),
    .in_end_of_source (in_end_of_source),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_start_offset (out_start_offset),
    .out_token_length (out_token_length),
    .out_line_number  (out_line_number),
    .out_start_column (out_start_column),
    .out_last_of_run  (out_last_of_run)
  );

  // bytes waiting to be offered, and tokens predicted but not yet seen
  src_byte_t       source_q[$];
  expected_token_t expected_tokens[$];

  int cycle_count = 0;
  int calm_from = 32'h7fff_0000;
  logic calm;
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;
  int hold_left = 0;

  int mismatch_count = 0;
  int bytes_accepted = 0;
  int tokens_checked = 0;
  int random_bytes = 0;

  src_byte_t       next_byte;
  expected_token_t want;

  // predictor state: a private copy of the scanner
  scan_mode_e lex_mode;
  offset_t    pos;
  offset_t    tok_start;
  col_t       tok_col;
  line_t      line_no;
  col_t       col;
  logic       restarted;
  int         step_count;

  // no idling on either side inside this window
  assign calm = (cycle_count >= calm_from) && (cycle_count < calm_from + CALM_CYCLES);

  initial begin
    forever #2 clk = ~clk;
  end

  //--------------------------------------------------------------------------
  // predictor
  //--------------------------------------------------------------------------

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  // kind of a pending operator, alone or with its second character
  function automatic kind_t op_kind(scan_mode_e m, logic doubled);
    case (m)
      SCAN_EQ_PEND:   return doubled ? K_EQ  : K_ASSIGN;
      SCAN_BANG_PEND: return doubled ? K_NE  : K_NOT;
      SCAN_GT_PEND:   return doubled ? K_GE  : K_GT;
      SCAN_LT_PEND:   return doubled ? K_LE  : K_LT;
      SCAN_PLUS_PEND: return doubled ? K_INC : K_PLUS;
      default:        return doubled ? K_DEC : K_MINUS;
    endcase
  endfunction

  // one predicted token; line is always the current one, length saturates
  function automatic void emit(kind_t k, offset_t s, offset_t n, col_t c);
    expected_token_t e;
    if (step_count >= MAX_TOKENS) return;
    e.tok.kind  = k;
    e.tok.start = s;
    e.tok.len   = (n > offset_t'(LEN_MAX)) ? LEN_MAX : len_t'(n);
    e.tok.line  = line_no;
    e.tok.col   = c;
    e.last      = 1'b0;
    expected_tokens.push_back(e);
    step_count++;
  endfunction

  function automatic offset_t tok_len();
    return (pos >= tok_start) ? pos - tok_start : offset_t'(0);
  endfunction

  // move past one byte, all counters saturating
  function automatic void advance(logic [7:0] c);
    if (c == CH_NL) begin
      if (line_no != LINE_TOP) line_no++;
      col = col_t'(1);
    end else if (col != COLUMN_TOP) begin
      col++;
    end
    if (pos != OFFSET_TOP) pos++;
  endfunction

  function automatic void scan_restart();
    lex_mode  = SCAN_IDLE;
    pos       = '0;
    tok_start = '0;
    tok_col   = col_t'(1);
    line_no   = line_t'(1);
    col       = col_t'(1);
  endfunction

  function automatic void start_lexeme(scan_mode_e m, logic [7:0] c);
    tok_start = pos;
    tok_col   = col;
    lex_mode  = m;
    advance(c);
  endfunction

  function automatic void emit_single(kind_t k, logic [7:0] c);
    emit(k, pos, offset_t'(1), col);
    advance(c);
  endfunction

  // number followed by a dot and a non-digit: number, bad dot, then error
  function automatic void dot_fail();
    offset_t n;
    n = tok_len();
    emit(K_NUMBER, tok_start, (n != '0) ? n - offset_t'(1) : offset_t'(0), tok_col);
    emit(K_BAD, (pos != '0) ? pos - offset_t'(1) : offset_t'(0), offset_t'(1),
         (col > col_t'(1)) ? col - col_t'(1) : col_t'(1));
    lex_mode = SCAN_ERROR;
  endfunction

  // decide what a byte starts when nothing is pending
  function automatic void dispatch(logic [7:0] c);
    lex_mode = SCAN_IDLE;
    case (c)
      "(": emit_single(K_LPAREN, c);
      ")": emit_single(K_RPAREN, c);
      "[": emit_single(K_LBRACKET, c);
      "]": emit_single(K_RBRACKET, c);
      "{": emit_single(K_LBRACE, c);
      "}": emit_single(K_RBRACE, c);
      ";": emit_single(K_SEMI, c);
      "*": emit_single(K_STAR, c);
      "=": start_lexeme(SCAN_EQ_PEND, c);
      "!": start_lexeme(SCAN_BANG_PEND, c);
      ">": start_lexeme(SCAN_GT_PEND, c);
      "<": start_lexeme(SCAN_LT_PEND, c);
      "+": start_lexeme(SCAN_PLUS_PEND, c);
      "-": start_lexeme(SCAN_MINUS_PEND, c);
      "/": start_lexeme(SCAN_SLASH, c);
      "\"": start_lexeme(SCAN_STRING, c);
      " ", CH_TAB, CH_CR, CH_NL: advance(c);
      CH_NUL: begin
        emit(K_EOF, pos, offset_t'(0), col);
        scan_restart();
        restarted = 1'b1;
      end
      default: begin
        if (is_digit(c)) begin
          start_lexeme(SCAN_INT, c);
        end else if (is_alpha(c)) begin
          start_lexeme(SCAN_IDENT, c);
        end else begin
          emit(K_BAD, pos, offset_t'(1), col);
          lex_mode = SCAN_ERROR;
        end
      end
    endcase
  endfunction

  // tokens caused by one accepted byte transaction, appended to expected_tokens
  function automatic void scan_byte(logic [7:0] c, logic eos);
    scan_mode_e m;
    logic [7:0] second;
    m = lex_mode;
    step_count = 0;
    restarted = 1'b0;
    case (m)
      SCAN_EQ_PEND, SCAN_BANG_PEND, SCAN_GT_PEND, SCAN_LT_PEND, SCAN_PLUS_PEND,
      SCAN_MINUS_PEND: begin
        second = (m == SCAN_PLUS_PEND) ? "+" : ((m == SCAN_MINUS_PEND) ? "-" : "=");
        if (c == second) begin
          emit(op_kind(m, 1'b1), tok_start, offset_t'(2), tok_col);
          advance(c);
          lex_mode = SCAN_IDLE;
        end else begin
          emit(op_kind(m, 1'b0), tok_start, offset_t'(1), tok_col);
          dispatch(c);
        end
      end
      SCAN_ERROR: begin
        // swallowed, counters hold
      end
      SCAN_SLASH: begin
        if (c == "/") begin
          lex_mode = SCAN_COMMENT;
          advance(c);
        end else begin
          emit(K_SLASH, tok_start, offset_t'(1), tok_col);
          dispatch(c);
        end
      end
      SCAN_COMMENT: begin
        if (c == CH_NL) dispatch(c);
        else advance(c);
      end
      SCAN_INT: begin
        if (is_digit(c)) begin
          advance(c);
        end else if (c == ".") begin
          advance(c);
          lex_mode = SCAN_DOT;
        end else begin
          emit(K_NUMBER, tok_start, tok_len(), tok_col);
          dispatch(c);
        end
      end
      SCAN_DOT: begin
        if (is_digit(c)) begin
          advance(c);
          lex_mode = SCAN_FRAC;
        end else begin
          dot_fail();
        end
      end
      SCAN_FRAC, SCAN_IDENT: begin
        if (is_digit(c) || (m == SCAN_IDENT && is_alpha(c))) begin
          advance(c);
        end else begin
          emit((m == SCAN_FRAC) ? K_NUMBER : K_IDENT, tok_start, tok_len(), tok_col);
          dispatch(c);
        end
      end
      SCAN_STRING: begin
        if (c == "\"") begin
          advance(c);
          emit(K_STRING, tok_start, tok_len(), tok_col);
          lex_mode = SCAN_IDLE;
        end else if (c == CH_NL) begin
          emit(K_UNTERM, tok_start, tok_len(), tok_col);
          lex_mode = SCAN_ERROR;
        end else begin
          advance(c);
        end
      end
      default: dispatch(c);
    endcase

    // end of source: finish what is pending, then eof and start over
    if (eos && !restarted) begin
      case (lex_mode)
        SCAN_EQ_PEND, SCAN_BANG_PEND, SCAN_GT_PEND, SCAN_LT_PEND, SCAN_PLUS_PEND,
        SCAN_MINUS_PEND: emit(op_kind(lex_mode, 1'b0), tok_start, offset_t'(1), tok_col);
        SCAN_SLASH:      emit(K_SLASH, tok_start, offset_t'(1), tok_col);
        SCAN_INT, SCAN_FRAC: emit(K_NUMBER, tok_start, tok_len(), tok_col);
        SCAN_DOT:        dot_fail();
        SCAN_IDENT:      emit(K_IDENT, tok_start, tok_len(), tok_col);
        SCAN_STRING:     emit(K_UNTERM, tok_start, tok_len(), tok_col);
        default: begin
        end
      endcase
      emit(K_EOF, pos, offset_t'(0), col);
      scan_restart();
    end

    if (step_count != 0) expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endfunction

  //--------------------------------------------------------------------------
  // stimulus helpers
  //--------------------------------------------------------------------------

  task automatic add_byte(logic [7:0] c, logic eos);
    src_byte_t b;
    b.c = c;
    b.eos = eos;
    source_q.push_back(b);
  endtask

  task automatic add_text(string s, logic end_it);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], end_it && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] rand_alpha();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'(97 + r);
    if (r < 52) return 8'(65 + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(48 + $urandom_range(0, 9));
  endfunction

  // one lexeme of random content, mostly well formed, some noise and breakage
  task automatic add_lexeme();
    string singles;
    string ops;
    string pairs;
    string blanks;
    int pick;
    int i;
    logic [7:0] c;
    singles = "(){}[];*";
    ops     = "=!><+-";
    pairs   = "====+-";
    blanks  = " \t\r\n";
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      add_byte(singles[$urandom_range(0, 7)], 1'b0);
    end else if (pick < 26) begin
      i = $urandom_range(0, 5);
      add_byte(ops[i], 1'b0);
      if ($urandom_range(0, 1)) add_byte(pairs[i], 1'b0);
    end else if (pick < 40) begin
      repeat ($urandom_range(1, 4)) add_byte(rand_digit(), 1'b0);
      i = $urandom_range(0, 19);
      if (i < 5) begin
        add_byte(".", 1'b0);
        repeat ($urandom_range(1, 3)) add_byte(rand_digit(), 1'b0);
      end else if (i == 5) begin
        // dot followed by a non-digit
        add_byte(".", 1'b0);
        add_byte(rand_alpha(), 1'b0);
      end
    end else if (pick < 54) begin
      add_byte(rand_alpha(), 1'b0);
      repeat ($urandom_range(0, 5)) begin
        add_byte($urandom_range(0, 2) == 0 ? rand_digit() : rand_alpha(), 1'b0);
      end
    end else if (pick < 62) begin
      add_byte("\"", 1'b0);
      repeat ($urandom_range(0, 6)) begin
        c = 8'($urandom_range(0, 255));
        while (c == "\"" || c == CH_NL) c = 8'($urandom_range(0, 255));
        add_byte(c, 1'b0);
      end
      // a newline instead of the closing quote leaves the string open
      add_byte($urandom_range(0, 9) == 0 ? CH_NL : 8'("\""), 1'b0);
    end else if (pick < 70) begin
      add_text("//", 1'b0);
      repeat ($urandom_range(0, 8)) begin
        c = 8'($urandom_range(0, 255));
        while (c == CH_NL) c = 8'($urandom_range(0, 255));
        add_byte(c, 1'b0);
      end
      add_byte(CH_NL, 1'b0);
    end else if (pick < 90) begin
      add_byte(blanks[$urandom_range(0, 3)], 1'b0);
    end else if (pick < 94) begin
      add_byte("/", 1'b0);
      add_byte(blanks[$urandom_range(0, 3)], 1'b0);
    end else begin
      add_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // sender pause: nothing offered, nothing outstanding
  task automatic wait_drained();
    while (source_q.size() != 0 || in_valid || expected_tokens.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
  endtask

  //--------------------------------------------------------------------------
  // driver: offers queued bytes, predicts tokens on every accepted transaction
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        scan_byte(in_char_byte, in_end_of_source);
        bytes_accepted++;
      end
      // the slot is free once the current byte is gone or none was offered
      if (!in_valid || in_ready) begin
        if (source_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          next_byte = source_q.pop_front();
          in_valid         <= 1'b1;
          in_char_byte     <= next_byte.c;
          in_end_of_source <= next_byte.eos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  //--------------------------------------------------------------------------
  // receiver: random stalls plus one long hold that backs the block up
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_req && !long_hold_done) begin
      out_ready      <= 1'b0;
      hold_left      <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  //--------------------------------------------------------------------------
  // monitor: every token transaction against the oldest prediction
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("token kind %0d at offset %0d with none expected",
                                  out_token_kind, out_start_offset));
      end else begin
        want = expected_tokens.pop_front();
        tokens_checked++;
        if (out_token_kind !== want.tok.kind)
          report_mismatch($sformatf("token %0d kind %0d, expected %0d",
                                    tokens_checked, out_token_kind, want.tok.kind));
        if (out_start_offset !== want.tok.start)
          report_mismatch($sformatf("token %0d offset %0d, expected %0d",
                                    tokens_checked, out_start_offset, want.tok.start));
        if (out_token_length !== want.tok.len)
          report_mismatch($sformatf("token %0d length %0d, expected %0d",
                                    tokens_checked, out_token_length, want.tok.len));
        if (out_line_number !== want.tok.line)
          report_mismatch($sformatf("token %0d line %0d, expected %0d",
                                    tokens_checked, out_line_number, want.tok.line));
        if (out_start_column !== want.tok.col)
          report_mismatch($sformatf("token %0d column %0d, expected %0d",
                                    tokens_checked, out_start_column, want.tok.col));
        if (out_last_of_run !== want.last)
          report_mismatch($sformatf("token %0d last flag %0b, expected %0b",
                                    tokens_checked, out_last_of_run, want.last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tokens outstanding",
               cycle_count, expected_tokens.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  //--------------------------------------------------------------------------
  // sequence: reset, directed sources, random sources
  //--------------------------------------------------------------------------
  initial begin
    scan_restart();
    restarted = 1'b0;
    step_count = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // every bracket, every one- and two-character operator
    add_text("(){}[];*==!=>=<=++--=!><+-/", 1'b0);
    // identifier, blanks, a fraction, then a dot before a letter
    add_text("zq_9 \t\r\n12.75 3.x#", 1'b1);
    // closed string, string broken by a newline, high bytes swallowed in error
    add_text("\"hi\"\"open\n", 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h80, 1'b1);
    // NUL kept inside a comment and inside a string, string open at the end
    add_text("//c", 1'b0);
    add_byte(CH_NUL, 1'b0);
    add_text("\n\"s", 1'b0);
    add_byte(CH_NUL, 1'b0);
    add_byte("t", 1'b1);
    // NUL as the last byte behind a number: one eof only
    add_byte("7", 1'b0);
    add_byte(CH_NUL, 1'b1);
    // pending tokens flushed at the end: dot, operator, slash
    add_text("4.", 1'b1);
    add_text("a+", 1'b1);
    add_text("/", 1'b1);
    // bad character at idle, then a bare NUL
    add_text("# ", 1'b1);
    add_byte(CH_NUL, 1'b0);
    wait_drained();

    // random sources, each closed by an end flag or a NUL
    while (random_bytes < RANDOM_BYTES) begin
      repeat ($urandom_range(1, 8)) add_lexeme();
      if ($urandom_range(0, 3) == 0) add_byte(CH_NUL, 1'($urandom_range(0, 1)));
      else source_q[source_q.size() - 1].eos = 1'b1;
      random_bytes = source_q.size();
    end
    long_hold_req <= 1'b1;
    calm_from <= cycle_count + 100;
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_tokens.size() != 0)
      report_mismatch($sformatf("%0d predicted tokens never arrived", expected_tokens.size()));

    $display("covered %0d source bytes (directed sources, random sources under stalls)",
             bytes_accepted);
    $display("checked %0d tokens, %0d mismatches", tokens_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
